/* hdl/sgci_pkg.sv */
// shared widths, register codes and inter-stage structs for the softened gravity cell block
// no dependencies
`default_nettype none

package sgci_pkg;

  localparam int POS_W   = 32;
  localparam int IDX_W   = 16;
  localparam int CNT_W   = 17;
  localparam int CFG_W   = 32;
  localparam int RATIO_W = 16;
  localparam int R2_W    = 66;
  localparam int ROOT_W  = 33;
  localparam int XQ_W    = 31;
  localparam int NUM_W   = 98;
  localparam int DEN_W   = 102;
  localparam int DVQ_W   = 32;

  localparam logic [CFG_W-1:0]   FORCE_SCALE_RST = 32'd16777216;
  localparam logic [CFG_W-1:0]   SOFTENING_RST   = 32'd65536;
  localparam logic [RATIO_W-1:0] RATIO_RST       = 16'd2048;
  localparam logic [XQ_W-1:0]    X_ONE           = 31'h4000_0000;

  typedef enum logic [1:0] {
    CFG_FORCE_SCALE,
    CFG_SOFTENING,
    CFG_OPENING
  } cfg_idx_e;

  typedef struct packed {
    logic [POS_W-1:0] part_x;
    logic [POS_W-1:0] part_y;
    logic [POS_W-1:0] part_z;
    logic [IDX_W-1:0] particle_index;
    logic [POS_W-1:0] com_x;
    logic [POS_W-1:0] com_y;
    logic [POS_W-1:0] com_z;
    logic [POS_W-1:0] cell_size;
    logic [CNT_W-1:0] cell_count;
    logic [IDX_W-1:0] resident_index;
  } in_t;

  typedef struct packed {
    logic [POS_W-1:0] ad;
    logic             neg;
  } lane_t;

  typedef struct packed {
    lane_t [2:0]     lane;
    logic [R2_W-1:0] r2;
    logic            beyond;
    logic            open_hit;
    logic            kick;
  } front_t;

  typedef struct packed {
    logic [ROOT_W-1:0] r;
    front_t            f;
  } root_t;

  typedef struct packed {
    logic [2:0] neg;
    logic [2:0] ovf;
    logic       open_hit;
    logic       kick;
    logic       zero;
  } kern_t;

endpackage

`default_nettype wire

/* hdl/softened_gravity_cell_interaction.sv */
// top level: config registers, input skid, pipeline assembly and saturating output register
// depends on sgci_pkg, sgci_front, sgci_sqrt, sgci_div, sgci_kernel
`default_nettype none

// Takes one particle-cell pair per clock while the output is not stalled and returns one
// result per pair, in order, through 4 front stages, 33 square-root stages, 31 stages for
// the softening ratio divide, 6 kernel stages, 32 stages of the final divide and 1 output
// register. The bit-serial square root and the two restoring dividers make up most stages;
// the whole pipeline advances as one whenever the output register is free or being read,
// and a one-item skid register at the input takes a pair while a result waits. Config writes
// are always ready, so write them only while no items are in flight.
module softened_gravity_cell_interaction import sgci_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [CFG_W-1:0]    cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [POS_W-1:0] part_x_i,
  input  logic signed [POS_W-1:0] part_y_i,
  input  logic signed [POS_W-1:0] part_z_i,
  input  logic [IDX_W-1:0]    particle_index_i,
  input  logic signed [POS_W-1:0] com_x_i,
  input  logic signed [POS_W-1:0] com_y_i,
  input  logic signed [POS_W-1:0] com_z_i,
  input  logic [POS_W-1:0]    cell_size_i,
  input  logic [CNT_W-1:0]    cell_count_i,
  input  logic [IDX_W-1:0]    resident_index_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                open_cell_o,
  output logic                kick_applied_o,
  output logic signed [DVQ_W-1:0] dvx_o,
  output logic signed [DVQ_W-1:0] dvy_o,
  output logic signed [DVQ_W-1:0] dvz_o
);

  logic [CFG_W-1:0]   fs_q;
  logic [CFG_W-1:0]   soft_q;
  logic [RATIO_W-1:0] ratio_q;
  logic [63:0]        s2_q;
  logic [63:0]        s3lo_q;
  logic [63:0]        s3hi_q;
  logic [DEN_W-1:0]   den_near_q;

  logic  en;
  logic  skid_v_q;
  in_t   skid_q;
  in_t   in_item;
  in_t   feed;
  logic  feed_vld;

  logic   front_vld;
  front_t front_item;

  logic              root_vld;
  logic [ROOT_W-1:0] root;
  front_t            root_side;
  root_t             root_item;

  logic                   xd_vld;
  logic [0:0][XQ_W-1:0]   xd_quo;
  root_t                  xd_item;

  logic                  kern_vld;
  logic [2:0][NUM_W-1:0] kern_num;
  logic [DEN_W-1:0]      kern_den;
  kern_t                 kern_flag;

  logic                  fd_vld;
  logic [2:0][DVQ_W-1:0] fd_quo;
  kern_t                 fd_flag;

  logic [2:0][DVQ_W-1:0] lim;
  logic [2:0][DVQ_W-1:0] mag;
  logic [2:0][DVQ_W-1:0] dv_d;
  logic [2:0][DVQ_W-1:0] dv_q;
  logic                  out_vld_q;
  logic                  open_q;
  logic                  kick_q;

  // config registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_q    <= FORCE_SCALE_RST;
      soft_q  <= SOFTENING_RST;
      ratio_q <= RATIO_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_FORCE_SCALE: fs_q    <= cfg_data_i;
        CFG_SOFTENING:   soft_q  <= cfg_data_i;
        CFG_OPENING:     ratio_q <= cfg_data_i[RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  // derived softening terms, registered through s2_q, then s3lo_q and s3hi_q, then den_near_q
  always_ff @(posedge clk_i) begin
    s2_q       <= 64'(soft_q) * 64'(soft_q);
    s3lo_q     <= 64'(s2_q[31:0]) * 64'(soft_q);
    s3hi_q     <= 64'(s2_q[63:32]) * 64'(soft_q);
    den_near_q <= {(96'(s3lo_q) + (96'(s3hi_q) << 32)), 6'b0};
  end

  // input skid and pipeline enable
  assign en         = ~out_vld_q | out_ready_i;
  assign in_ready_o = ~skid_v_q;

  always_comb begin
    in_item.part_x         = part_x_i;
    in_item.part_y         = part_y_i;
    in_item.part_z         = part_z_i;
    in_item.particle_index = particle_index_i;
    in_item.com_x          = com_x_i;
    in_item.com_y          = com_y_i;
    in_item.com_z          = com_z_i;
    in_item.cell_size      = cell_size_i;
    in_item.cell_count     = cell_count_i;
    in_item.resident_index = resident_index_i;
    feed     = skid_v_q ? skid_q : in_item;
    feed_vld = skid_v_q | in_valid_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_v_q <= 1'b0;
    end else if (en) begin
      skid_v_q <= 1'b0;
    end else if (in_valid_i && !skid_v_q) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!en && in_valid_i && !skid_v_q) begin
      skid_q <= in_item;
    end
  end

  sgci_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (feed_vld),
    .item_i (feed),
    .ratio_i(ratio_q),
    .s2_i   (s2_q),
    .vld_o  (front_vld),
    .item_o (front_item)
  );

  sgci_sqrt #(
    .N_W   (R2_W),
    .SIDE_W($bits(front_t))
  ) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (front_vld),
    .rad_i  (front_item.r2),
    .side_i (front_item),
    .vld_o  (root_vld),
    .root_o (root),
    .side_o (root_side)
  );

  always_comb begin
    root_item.r = root;
    root_item.f = root_side;
  end

  sgci_div #(
    .LANES (1),
    .N_W   (ROOT_W + 30),
    .D_W   (CFG_W),
    .Q_W   (XQ_W),
    .SIDE_W($bits(root_t))
  ) u_xdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (root_vld),
    .num_i  ({root, 30'b0}),
    .den_i  (soft_q),
    .side_i (root_item),
    .vld_o  (xd_vld),
    .quo_o  (xd_quo),
    .side_o (xd_item)
  );

  sgci_kernel u_kernel (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .vld_i     (xd_vld),
    .x_i       (xd_quo[0]),
    .item_i    (xd_item),
    .fs_i      (fs_q),
    .den_near_i(den_near_q),
    .s_zero_i  (soft_q == '0),
    .vld_o     (kern_vld),
    .num_o     (kern_num),
    .den_o     (kern_den),
    .flag_o    (kern_flag)
  );

  sgci_div #(
    .LANES (3),
    .N_W   (NUM_W),
    .D_W   (DEN_W),
    .Q_W   (DVQ_W),
    .SIDE_W($bits(kern_t))
  ) u_kdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (kern_vld),
    .num_i  (kern_num),
    .den_i  (kern_den),
    .side_i (kern_flag),
    .vld_o  (fd_vld),
    .quo_o  (fd_quo),
    .side_o (fd_flag)
  );

  // saturate and sign the increments
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lim[i]  = fd_flag.neg[i] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      mag[i]  = (fd_flag.ovf[i] || fd_quo[i] > lim[i]) ? lim[i] : fd_quo[i];
      dv_d[i] = (fd_flag.kick && !fd_flag.zero)
              ? (fd_flag.neg[i] ? DVQ_W'(0) - mag[i] : mag[i]) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= fd_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      open_q <= fd_flag.open_hit;
      kick_q <= fd_flag.kick;
      dv_q   <= dv_d;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign open_cell_o    = open_q;
  assign kick_applied_o = kick_q;
  assign dvx_o          = dv_q[0];
  assign dvy_o          = dv_q[1];
  assign dvz_o          = dv_q[2];

endmodule

`default_nettype wire

/* hdl/sgci_front.sv */
// front stages: position deltas, squared distance, opening test and kick decision
// depends on sgci_pkg
`default_nettype none

module sgci_front import sgci_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  in_t                item_i,
  input  logic [RATIO_W-1:0] ratio_i,
  input  logic [63:0]        s2_i,
  output logic               vld_o,
  output front_t             item_o
);

  typedef struct packed {
    lane_t [2:0] lane;
    logic [47:0] osz;
    logic        multi;
    logic        empty;
    logic        self_hit;
  } s1_t;

  typedef struct packed {
    lane_t [2:0]       lane;
    logic [2:0][63:0]  sq;
    logic [63:0]       ozl2;
    logic [47:0]       ozm;
    logic [31:0]       ozh2;
    logic              multi;
    logic              empty;
    logic              self_hit;
  } s2_t;

  typedef struct packed {
    lane_t [2:0]     lane;
    logic [R2_W-1:0] r2;
    logic [95:0]     rhs;
    logic            multi;
    logic            empty;
    logic            self_hit;
  } s3_t;

  logic [3:0]             vld_q;
  logic [2:0][POS_W-1:0]  part;
  logic [2:0][POS_W-1:0]  com;
  logic [2:0][POS_W:0]    dif;
  logic [2:0][POS_W:0]    mag;
  logic                   theta_ok;
  s1_t    s1_d, s1_q;
  s2_t    s2_d, s2_q;
  s3_t    s3_d, s3_q;
  front_t item_d, item_q;

  assign part = {item_i.part_z, item_i.part_y, item_i.part_x};
  assign com  = {item_i.com_z, item_i.com_y, item_i.com_x};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dif[i] = {com[i][POS_W-1], com[i]} - {part[i][POS_W-1], part[i]};
      mag[i] = (POS_W+1)'(0) - dif[i];
      s1_d.lane[i].neg = dif[i][POS_W];
      s1_d.lane[i].ad  = dif[i][POS_W] ? mag[i][POS_W-1:0] : dif[i][POS_W-1:0];
    end
    s1_d.osz      = 48'(ratio_i) * 48'(item_i.cell_size);
    s1_d.multi    = item_i.cell_count > CNT_W'(1);
    s1_d.empty    = item_i.cell_count == '0;
    s1_d.self_hit = (item_i.cell_count == CNT_W'(1)) &&
                    (item_i.resident_index == item_i.particle_index);
  end

  always_comb begin
    s2_d.lane = s1_q.lane;
    for (int i = 0; i < 3; i++) begin
      s2_d.sq[i] = 64'(s1_q.lane[i].ad) * 64'(s1_q.lane[i].ad);
    end
    s2_d.ozl2     = 64'(s1_q.osz[31:0]) * 64'(s1_q.osz[31:0]);
    s2_d.ozm      = 48'(s1_q.osz[31:0]) * 48'(s1_q.osz[47:32]);
    s2_d.ozh2     = 32'(s1_q.osz[47:32]) * 32'(s1_q.osz[47:32]);
    s2_d.multi    = s1_q.multi;
    s2_d.empty    = s1_q.empty;
    s2_d.self_hit = s1_q.self_hit;
  end

  always_comb begin
    s3_d.lane     = s2_q.lane;
    s3_d.r2       = R2_W'(s2_q.sq[0]) + R2_W'(s2_q.sq[1]) + R2_W'(s2_q.sq[2]);
    s3_d.rhs      = 96'(s2_q.ozl2) + (96'(s2_q.ozm) << 33) + (96'(s2_q.ozh2) << 64);
    s3_d.multi    = s2_q.multi;
    s3_d.empty    = s2_q.empty;
    s3_d.self_hit = s2_q.self_hit;
  end

  always_comb begin
    theta_ok        = (96'(s3_q.r2) << 24) > s3_q.rhs;
    item_d.lane     = s3_q.lane;
    item_d.r2       = s3_q.r2;
    item_d.beyond   = s3_q.r2 > R2_W'(s2_i);
    item_d.open_hit = s3_q.multi & ~(theta_ok & item_d.beyond);
    item_d.kick     = ~item_d.open_hit & ~s3_q.empty & ~s3_q.self_hit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q   <= s1_d;
      s2_q   <= s2_d;
      s3_q   <= s3_d;
      item_q <= item_d;
    end
  end

  assign vld_o  = vld_q[3];
  assign item_o = item_q;

endmodule

`default_nettype wire

/* hdl/sgci_sqrt.sv */
// pipelined integer square root, one result bit per stage
// no dependencies
`default_nettype none

module sgci_sqrt #(
  parameter int N_W    = 66,
  parameter int SIDE_W = 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   vld_i,
  input  logic [N_W-1:0]         rad_i,
  input  logic [SIDE_W-1:0]      side_i,
  output logic                   vld_o,
  output logic [(N_W+1)/2-1:0]   root_o,
  output logic [SIDE_W-1:0]      side_o
);

  localparam int R_W = (N_W + 1) / 2;
  localparam int T_W = N_W + 2;

  logic              vld_s  [R_W+1];
  logic [N_W-1:0]    rem_s  [R_W+1];
  logic [R_W-1:0]    res_s  [R_W+1];
  logic [SIDE_W-1:0] side_s [R_W+1];

  always_comb begin
    vld_s[0]  = vld_i;
    rem_s[0]  = rad_i;
    res_s[0]  = '0;
    side_s[0] = side_i;
  end

  for (genvar j = 1; j <= R_W; j++) begin : g_stage
    localparam int K = R_W - j;
    logic [T_W-1:0] trial;
    logic           fit;

    always_comb begin
      trial = (T_W'(res_s[j-1]) << (K + 1)) + (T_W'(1) << (2 * K));
      fit   = T_W'(rem_s[j-1]) >= trial;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_s[j] <= 1'b0;
      end else if (en_i) begin
        vld_s[j] <= vld_s[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_s[j] <= side_s[j-1];
        if (fit) begin
          rem_s[j] <= N_W'(T_W'(rem_s[j-1]) - trial);
          res_s[j] <= res_s[j-1] | (R_W'(1) << K);
        end else begin
          rem_s[j] <= rem_s[j-1];
          res_s[j] <= res_s[j-1];
        end
      end
    end
  end

  assign vld_o  = vld_s[R_W];
  assign root_o = res_s[R_W];
  assign side_o = side_s[R_W];

endmodule

`default_nettype wire

/* hdl/sgci_div.sv */
// pipelined restoring divider, one quotient bit per stage, LANES numerators over one divisor
// no dependencies; quotient is valid when num < den * 2**Q_W
`default_nettype none

module sgci_div #(
  parameter int LANES  = 1,
  parameter int N_W    = 63,
  parameter int D_W    = 32,
  parameter int Q_W    = 31,
  parameter int SIDE_W = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        vld_i,
  input  logic [LANES-1:0][N_W-1:0]   num_i,
  input  logic [D_W-1:0]              den_i,
  input  logic [SIDE_W-1:0]           side_i,
  output logic                        vld_o,
  output logic [LANES-1:0][Q_W-1:0]   quo_o,
  output logic [SIDE_W-1:0]           side_o
);

  logic                      vld_s  [Q_W+1];
  logic [LANES-1:0][D_W:0]   rem_s  [Q_W+1];
  logic [LANES-1:0][N_W-1:0] num_s  [Q_W+1];
  logic [LANES-1:0][Q_W-1:0] quo_s  [Q_W+1];
  logic [D_W-1:0]            den_s  [Q_W+1];
  logic [SIDE_W-1:0]         side_s [Q_W+1];

  always_comb begin
    vld_s[0]  = vld_i;
    num_s[0]  = num_i;
    den_s[0]  = den_i;
    side_s[0] = side_i;
    quo_s[0]  = '0;
    for (int l = 0; l < LANES; l++) begin
      rem_s[0][l] = (D_W+1)'(num_i[l][N_W-1:Q_W]);
    end
  end

  for (genvar j = 1; j <= Q_W; j++) begin : g_stage
    localparam int B = Q_W - j;
    logic [LANES-1:0][D_W:0] trial;
    logic [LANES-1:0]        fit;

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        trial[l] = {rem_s[j-1][l][D_W-1:0], num_s[j-1][l][B]};
        fit[l]   = trial[l] >= {1'b0, den_s[j-1]};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_s[j] <= 1'b0;
      end else if (en_i) begin
        vld_s[j] <= vld_s[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_s[j]  <= num_s[j-1];
        den_s[j]  <= den_s[j-1];
        side_s[j] <= side_s[j-1];
        for (int l = 0; l < LANES; l++) begin
          rem_s[j][l] <= fit[l] ? trial[l] - {1'b0, den_s[j-1]} : trial[l];
          quo_s[j][l] <= quo_s[j-1][l] | (Q_W'(fit[l]) << B);
        end
      end
    end
  end

  assign vld_o  = vld_s[Q_W];
  assign quo_o  = quo_s[Q_W];
  assign side_o = side_s[Q_W];

endmodule

`default_nettype wire

/* hdl/sgci_kernel.sv */
// kernel stages: softening polynomial, far-field denominator, numerators and overflow check
// depends on sgci_pkg
`default_nettype none

module sgci_kernel import sgci_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        vld_i,
  input  logic [XQ_W-1:0]             x_i,
  input  root_t                       item_i,
  input  logic [CFG_W-1:0]            fs_i,
  input  logic [DEN_W-1:0]            den_near_i,
  input  logic                        s_zero_i,
  output logic                        vld_o,
  output logic [2:0][NUM_W-1:0]       num_o,
  output logic [DEN_W-1:0]            den_o,
  output kern_t                       flag_o
);

  typedef struct packed {
    logic [2:0] neg;
    logic       beyond;
    logic       open_hit;
    logic       kick;
    logic       zero;
  } kf_t;

  typedef struct packed {
    logic [XQ_W-1:0]  xc;
    logic [XQ_W-1:0]  x2;
    logic [2:0][63:0] kd;
    logic [64:0]      pr_lo;
    logic [66:0]      pr_hi;
    kf_t              f;
  } k1_t;

  typedef struct packed {
    logic [XQ_W-1:0]  xc;
    logic [XQ_W-1:0]  x3;
    logic [2:0][63:0] kd;
    logic [98:0]      den_far;
    kf_t              f;
  } k2_t;

  typedef struct packed {
    logic [33:0]      p;
    logic [2:0][63:0] kd;
    logic [DEN_W-1:0] den;
    kf_t              f;
  } k3_t;

  typedef struct packed {
    logic [2:0][65:0] nl;
    logic [2:0][65:0] nh;
    logic [2:0][63:0] kd;
    logic [DEN_W-1:0] den;
    kf_t              f;
  } k4_t;

  typedef struct packed {
    logic [2:0][NUM_W-1:0] num;
    logic [DEN_W-1:0]      den;
    kf_t                   f;
  } k5_t;

  logic [5:0]  vld_q;
  logic [61:0] xsq;
  logic [61:0] xcu;
  logic [34:0] pa;
  logic [34:0] pb;
  k1_t k1_d, k1_q;
  k2_t k2_d, k2_q;
  k3_t k3_d, k3_q;
  k4_t k4_d, k4_q;
  k5_t k5_d, k5_q;
  logic [2:0][NUM_W-1:0] num_d, num_q;
  logic [DEN_W-1:0]      den_q;
  kern_t                 flag_d, flag_q;

  always_comb begin
    k1_d.xc = (x_i > X_ONE) ? X_ONE : x_i;
    xsq     = 62'(k1_d.xc) * 62'(k1_d.xc);
    k1_d.x2 = xsq[60:30];
    for (int i = 0; i < 3; i++) begin
      k1_d.kd[i]    = 64'(fs_i) * 64'(item_i.f.lane[i].ad);
      k1_d.f.neg[i] = item_i.f.lane[i].neg;
    end
    k1_d.pr_lo      = 65'(item_i.f.r2[31:0]) * 65'(item_i.r);
    k1_d.pr_hi      = 67'(item_i.f.r2[R2_W-1:32]) * 67'(item_i.r);
    k1_d.f.beyond   = item_i.f.beyond;
    k1_d.f.open_hit = item_i.f.open_hit;
    k1_d.f.kick     = item_i.f.kick;
    k1_d.f.zero     = item_i.f.kick & ~item_i.f.beyond & s_zero_i;
  end

  always_comb begin
    xcu          = 62'(k1_q.x2) * 62'(k1_q.xc);
    k2_d.xc      = k1_q.xc;
    k2_d.x3      = xcu[60:30];
    k2_d.kd      = k1_q.kd;
    k2_d.den_far = 99'(k1_q.pr_lo) + (99'(k1_q.pr_hi) << 32);
    k2_d.f       = k1_q.f;
  end

  always_comb begin
    pa       = (35'd1 << 33) + (35'(k2_q.x3) << 1);
    pb       = 35'(k2_q.xc) * 35'd9;
    k3_d.p   = (pa > pb) ? 34'(pa - pb) : '0;
    k3_d.kd  = k2_q.kd;
    k3_d.den = k2_q.f.beyond ? DEN_W'(k2_q.den_far) : den_near_i;
    k3_d.f   = k2_q.f;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      k4_d.nl[i] = 66'(k3_q.kd[i][31:0]) * 66'(k3_q.p);
      k4_d.nh[i] = 66'(k3_q.kd[i][63:32]) * 66'(k3_q.p);
    end
    k4_d.kd  = k3_q.kd;
    k4_d.den = k3_q.den;
    k4_d.f   = k3_q.f;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      k5_d.num[i] = k4_q.f.beyond ? (NUM_W'(k4_q.kd[i]) << 24)
                                  : NUM_W'(k4_q.nl[i]) + (NUM_W'(k4_q.nh[i]) << 32);
    end
    k5_d.den = k4_q.den;
    k5_d.f   = k4_q.f;
  end

  always_comb begin
    num_d = k5_q.num;
    for (int i = 0; i < 3; i++) begin
      flag_d.ovf[i] = (134'(k5_q.num[i]) >= (134'(k5_q.den) << 32));
    end
    flag_d.neg      = k5_q.f.neg;
    flag_d.open_hit = k5_q.f.open_hit;
    flag_d.kick     = k5_q.f.kick;
    flag_d.zero     = k5_q.f.zero;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[4:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      k1_q   <= k1_d;
      k2_q   <= k2_d;
      k3_q   <= k3_d;
      k4_q   <= k4_d;
      k5_q   <= k5_d;
      num_q  <= num_d;
      den_q  <= k5_q.den;
      flag_q <= flag_d;
    end
  end

  assign vld_o  = vld_q[5];
  assign num_o  = num_q;
  assign den_o  = den_q;
  assign flag_o = flag_q;

endmodule

`default_nettype wire
